// File: hdl/chm_pkg.sv
// ----------------------------------------------------------------------------
// chm_pkg
// Shared types and codes of the chained hash map engine.
// ----------------------------------------------------------------------------
package chm_pkg;

  localparam int ENTRY_W = 11;

  localparam logic [1:0] FUNC_ADD    = 2'd0;
  localparam logic [1:0] FUNC_REMOVE = 2'd1;
  localparam logic [1:0] FUNC_LOOKUP = 2'd2;

  localparam logic [2:0] ST_INSERTED  = 3'd0;
  localparam logic [2:0] ST_UPDATED   = 3'd1;
  localparam logic [2:0] ST_REMOVED   = 3'd2;
  localparam logic [2:0] ST_NOT_FOUND = 3'd3;
  localparam logic [2:0] ST_POOL_FULL = 3'd4;

  localparam logic [3:0] BIN_POWER_RESET = 4'd8;

  typedef struct packed {
    logic [1:0]  func;
    logic [63:0] key;
    logic [63:0] new_value;
    logic [63:0] miss_value;
  } req_t;

  typedef struct packed {
    logic [2:0]         status;
    logic               found;
    logic [63:0]        read_value;
    logic [ENTRY_W-1:0] entries;
  } rsp_t;

endpackage

// File: hdl/chm_if.sv
// ----------------------------------------------------------------------------
// chm_req_if / chm_rsp_if
// Valid/ready channels for operation items and result items.
// ----------------------------------------------------------------------------
interface chm_req_if;
  logic        valid;
  logic        ready;
  logic [1:0]  func;
  logic [63:0] key;
  logic [63:0] new_value;
  logic [63:0] miss_value;

  modport source (output valid, func, key, new_value, miss_value, input ready);
  modport sink (input valid, func, key, new_value, miss_value, output ready);
endinterface

interface chm_rsp_if;
  logic        valid;
  logic        ready;
  logic [2:0]  status;
  logic        found;
  logic [63:0] read_value;
  logic [10:0] entries;

  modport source (output valid, status, found, read_value, entries, input ready);
  modport sink (input valid, status, found, read_value, entries, output ready);
endinterface

// File: hdl/chm_ram.sv
// ----------------------------------------------------------------------------
// chm_ram
// Generic single-write, single-read RAM with registered read data.
// ----------------------------------------------------------------------------
module chm_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 16
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

// File: hdl/chm_front.sv
// ----------------------------------------------------------------------------
// chm_front
// Accepts items, hashes the key to a bin and queues them for the walker.
// ----------------------------------------------------------------------------
module chm_front #(
  parameter int BIN_POWER_MAX = 8,
  parameter int HASH_MULT     = 65521
) (
  input  logic                     clk,
  input  logic                     rst,
  input  logic [3:0]               bin_power,
  input  logic                     in_valid,
  output logic                     in_ready,
  input  chm_pkg::req_t            in_req,
  output logic                     q_valid,
  input  logic                     q_pop,
  output chm_pkg::req_t            q_req,
  output logic [BIN_POWER_MAX-1:0] q_bin
);

  localparam logic [15:0] MULT = HASH_MULT[15:0];

  chm_pkg::req_t            ent_req [2];
  logic [BIN_POWER_MAX-1:0] ent_bin [2];
  logic                     wr_ptr;
  logic                     rd_ptr;
  logic [1:0]               count;

  logic [31:0]              prod;
  logic [4:0]               pw;
  logic [BIN_POWER_MAX:0]   mask;
  logic [BIN_POWER_MAX-1:0] bin;
  logic                     push;
  logic                     pop;

  // only the low 16 product bits can reach the bin index
  always_comb begin
    prod = in_req.key[15:0] * MULT;
    if (bin_power == 4'd0) begin
      pw = 5'd1;
    end else if ({1'b0, bin_power} > 5'(BIN_POWER_MAX)) begin
      pw = 5'(BIN_POWER_MAX);
    end else begin
      pw = {1'b0, bin_power};
    end
    mask = ({{BIN_POWER_MAX{1'b0}}, 1'b1} << pw) - 1'b1;
    bin  = prod[BIN_POWER_MAX-1:0] & mask[BIN_POWER_MAX-1:0];
  end

  assign in_ready = (count != 2'd2);
  assign push     = in_valid && in_ready;
  assign q_valid  = (count != 2'd0);
  assign pop      = q_pop && q_valid;
  assign q_req    = ent_req[rd_ptr];
  assign q_bin    = ent_bin[rd_ptr];

  always_ff @(posedge clk) begin
    if (push) begin
      ent_req[wr_ptr] <= in_req;
      ent_bin[wr_ptr] <= bin;
    end
    if (rst) begin
      wr_ptr <= 1'b0;
      rd_ptr <= 1'b0;
      count  <= 2'd0;
    end else begin
      if (push) wr_ptr <= ~wr_ptr;
      if (pop) rd_ptr <= ~rd_ptr;
      count <= count + {1'b0, push} - {1'b0, pop};
    end
  end

endmodule

// File: hdl/chm_back.sv
// ----------------------------------------------------------------------------
// chm_back
// Chain walker: reads the bin head, follows links, then posts the result and, for adds and removes, updates the map.
// ----------------------------------------------------------------------------
module chm_back #(
  parameter int BIN_POWER_MAX = 8,
  parameter int NODE_COUNT    = 1024
) (
  input  logic                     clk,
  input  logic                     rst,
  input  logic                     q_valid,
  output logic                     q_pop,
  input  chm_pkg::req_t            q_req,
  input  logic [BIN_POWER_MAX-1:0] q_bin,
  output logic                     rsp_valid,
  input  logic                     rsp_ready,
  output chm_pkg::rsp_t            rsp_res
);

  localparam int BINS = 1 << BIN_POWER_MAX;
  localparam int NW   = $clog2(NODE_COUNT);
  localparam int LW   = $clog2(NODE_COUNT + 1);
  localparam logic [LW-1:0] NONE = LW'(NODE_COUNT);

  localparam logic [2:0] S_IDLE = 3'd0;
  localparam logic [2:0] S_HEAD = 3'd1;
  localparam logic [2:0] S_NODE = 3'd2;
  localparam logic [2:0] S_DONE = 3'd3;

  logic [2:0]               state;
  chm_pkg::req_t            cur_req;
  logic [BIN_POWER_MAX-1:0] cur_bin;
  logic [LW-1:0]            head;
  logic [LW-1:0]            cur;
  logic [LW-1:0]            prev;
  logic                     hit;
  logic [LW-1:0]            hit_link;
  logic [63:0]              hit_val;
  logic [BINS-1:0]          head_ok;
  logic [LW-1:0]            stack_cnt;
  logic [LW-1:0]            fresh;
  logic [LW-1:0]            total;

  logic [LW-1:0]            head_rd;
  logic [63:0]              key_rd;
  logic [63:0]              val_rd;
  logic [LW-1:0]            link_rd;
  logic [NW-1:0]            stack_rd;

  logic [LW-1:0]            head_eff;
  logic [NW-1:0]            node_raddr;
  logic                     out_free;
  logic                     fin;

  logic                     head_we;
  logic [LW-1:0]            head_wdata;
  logic                     key_we;
  logic                     val_we;
  logic [NW-1:0]            val_waddr;
  logic                     link_we;
  logic [NW-1:0]            link_waddr;
  logic [LW-1:0]            link_wdata;
  logic                     push;
  logic                     take;
  logic [NW-1:0]            new_node;
  logic                     pool_empty;
  logic [LW-1:0]            total_next;
  chm_pkg::rsp_t            res;

  assign head_eff   = head_ok[cur_bin] ? head_rd : NONE;
  assign node_raddr = (state == S_HEAD) ? head_eff[NW-1:0] : link_rd[NW-1:0];
  assign out_free   = !rsp_valid || rsp_ready;
  assign fin        = (state == S_DONE) && out_free;
  assign q_pop      = (state == S_IDLE) && q_valid;
  assign pool_empty = (stack_cnt == '0) && (fresh == NONE);
  assign new_node   = (stack_cnt != '0) ? stack_rd : fresh[NW-1:0];

  // result and map updates of the finishing item
  always_comb begin
    head_we    = 1'b0;
    head_wdata = LW'(new_node);
    key_we     = 1'b0;
    val_we     = 1'b0;
    val_waddr  = new_node;
    link_we    = 1'b0;
    link_waddr = new_node;
    link_wdata = head;
    push       = 1'b0;
    take       = 1'b0;
    total_next = total;
    res.status     = chm_pkg::ST_NOT_FOUND;
    res.found      = hit;
    res.read_value = 64'd0;
    case (cur_req.func)
      chm_pkg::FUNC_ADD: begin
        if (hit) begin
          val_we     = 1'b1;
          val_waddr  = cur[NW-1:0];
          res.status = chm_pkg::ST_UPDATED;
        end else if (pool_empty) begin
          res.status = chm_pkg::ST_POOL_FULL;
        end else begin
          take       = 1'b1;
          head_we    = 1'b1;
          key_we     = 1'b1;
          val_we     = 1'b1;
          link_we    = 1'b1;
          total_next = total + 1'b1;
          res.status = chm_pkg::ST_INSERTED;
        end
      end
      chm_pkg::FUNC_REMOVE: begin
        if (hit) begin
          if (prev == NONE) begin
            head_we    = 1'b1;
            head_wdata = hit_link;
          end else begin
            link_we    = 1'b1;
            link_waddr = prev[NW-1:0];
            link_wdata = hit_link;
          end
          push       = 1'b1;
          total_next = total - 1'b1;
          res.status = chm_pkg::ST_REMOVED;
        end
      end
      chm_pkg::FUNC_LOOKUP: begin
        if (hit) begin
          res.read_value = hit_val;
          res.status     = chm_pkg::ST_UPDATED;
        end else begin
          res.read_value = cur_req.miss_value;
        end
      end
      default: begin
        res.found = 1'b0;
      end
    endcase
    res.entries = chm_pkg::ENTRY_W'(total_next);
  end

  always_ff @(posedge clk) begin
    if (q_pop) begin
      cur_req <= q_req;
      cur_bin <= q_bin;
    end
    case (state)
      S_HEAD: begin
        head <= head_eff;
        cur  <= head_eff;
        prev <= NONE;
        hit  <= 1'b0;
      end
      S_NODE: begin
        if (key_rd == cur_req.key) begin
          hit      <= 1'b1;
          hit_link <= link_rd;
          hit_val  <= val_rd;
        end else begin
          prev <= cur;
          cur  <= link_rd;
        end
      end
      default: begin
      end
    endcase
    if (fin) begin
      rsp_res <= res;
    end
    if (rst) begin
      state     <= S_IDLE;
      head_ok   <= '0;
      stack_cnt <= '0;
      fresh     <= '0;
      total     <= '0;
      rsp_valid <= 1'b0;
    end else begin
      case (state)
        S_IDLE: begin
          if (q_valid) state <= S_HEAD;
        end
        S_HEAD: begin
          state <= (head_eff == NONE) ? S_DONE : S_NODE;
        end
        S_NODE: begin
          if (key_rd == cur_req.key || link_rd == NONE) state <= S_DONE;
        end
        S_DONE: begin
          if (out_free) state <= S_IDLE;
        end
        default: begin
          state <= S_IDLE;
        end
      endcase
      if (fin && head_we) head_ok[cur_bin] <= 1'b1;
      if (fin) begin
        total <= total_next;
        if (push) begin
          stack_cnt <= stack_cnt + 1'b1;
        end else if (take && stack_cnt != '0) begin
          stack_cnt <= stack_cnt - 1'b1;
        end else if (take) begin
          fresh <= fresh + 1'b1;
        end
      end
      if (fin) begin
        rsp_valid <= 1'b1;
      end else if (rsp_ready) begin
        rsp_valid <= 1'b0;
      end
    end
  end

  chm_ram #(.WIDTH(LW), .DEPTH(BINS)) u_heads (
    .clk(clk), .we(fin && head_we), .waddr(cur_bin), .wdata(head_wdata),
    .raddr(q_bin), .rdata(head_rd)
  );

  chm_ram #(.WIDTH(64), .DEPTH(NODE_COUNT)) u_keys (
    .clk(clk), .we(fin && key_we), .waddr(new_node), .wdata(cur_req.key),
    .raddr(node_raddr), .rdata(key_rd)
  );

  chm_ram #(.WIDTH(64), .DEPTH(NODE_COUNT)) u_values (
    .clk(clk), .we(fin && val_we), .waddr(val_waddr), .wdata(cur_req.new_value),
    .raddr(node_raddr), .rdata(val_rd)
  );

  chm_ram #(.WIDTH(LW), .DEPTH(NODE_COUNT)) u_links (
    .clk(clk), .we(fin && link_we), .waddr(link_waddr), .wdata(link_wdata),
    .raddr(node_raddr), .rdata(link_rd)
  );

  // top of the free stack is read continuously
  chm_ram #(.WIDTH(NW), .DEPTH(NODE_COUNT)) u_stack (
    .clk(clk), .we(fin && push), .waddr(stack_cnt[NW-1:0]), .wdata(cur[NW-1:0]),
    .raddr(NW'(stack_cnt - 1'b1)), .rdata(stack_rd)
  );

`ifndef SYNTHESIS
  a_pool_balance: assert property (@(posedge clk) disable iff (rst)
    ({1'b0, stack_cnt} + {1'b0, total}) == {1'b0, fresh})
    else $error("free nodes and held keys do not add up");

  a_total_range: assert property (@(posedge clk) disable iff (rst)
    total <= NONE)
    else $error("key count above pool size");

  a_found_status: assert property (@(posedge clk) disable iff (rst)
    rsp_valid && rsp_res.found |->
      rsp_res.status == chm_pkg::ST_UPDATED || rsp_res.status == chm_pkg::ST_REMOVED)
    else $error("found flag with wrong status");

  a_walk_done: assert property (@(posedge clk) disable iff (rst)
    fin |=> state == S_IDLE && rsp_valid)
    else $error("finish did not post a result");
`endif

endmodule

// File: hdl/chained_hash_map_engine.sv
// Item path: the front hashes and queues the item; the walker pops it, reads the bin
// head and walks the chain, one item at a time; the walk reads one node per cycle.
// A two-entry queue lets the front accept items while the walker is busy.
// Reset (rst, synchronous): all bins empty, all nodes free, zero keys, bin_power 8.
// ----------------------------------------------------------------------------
// chained_hash_map_engine
// Key-value map of 64-bit keys with chained bins and an APB register port.
// ----------------------------------------------------------------------------
module chained_hash_map_engine #(
  parameter int BIN_POWER_MAX = 8,
  parameter int NODE_COUNT    = 1024,
  parameter int HASH_MULT     = 65521
) (
  input  logic        clk,
  input  logic        rst,
  chm_req_if.sink     req,
  chm_rsp_if.source   rsp,
  input  logic        psel,
  input  logic        penable,
  input  logic        pwrite,
  input  logic [0:0]  paddr,
  input  logic [31:0] pwdata,
  output logic [31:0] prdata,
  output logic        pready
);

  logic [3:0]               bin_power;
  chm_pkg::req_t            in_req;
  chm_pkg::req_t            q_req;
  chm_pkg::rsp_t            rsp_res;
  logic [BIN_POWER_MAX-1:0] q_bin;
  logic                     q_valid;
  logic                     q_pop;

  assign pready = 1'b1;
  assign prdata = (paddr == 1'b0) ? {28'd0, bin_power} : 32'd0;

  always_ff @(posedge clk) begin
    if (rst) begin
      bin_power <= chm_pkg::BIN_POWER_RESET;
    end else if (psel && penable && pwrite && paddr == 1'b0) begin
      bin_power <= pwdata[3:0];
    end
  end

  assign in_req.func       = req.func;
  assign in_req.key        = req.key;
  assign in_req.new_value  = req.new_value;
  assign in_req.miss_value = req.miss_value;

  chm_front #(.BIN_POWER_MAX(BIN_POWER_MAX), .HASH_MULT(HASH_MULT)) u_front (
    .clk(clk), .rst(rst), .bin_power(bin_power),
    .in_valid(req.valid), .in_ready(req.ready), .in_req(in_req),
    .q_valid(q_valid), .q_pop(q_pop), .q_req(q_req), .q_bin(q_bin)
  );

  chm_back #(.BIN_POWER_MAX(BIN_POWER_MAX), .NODE_COUNT(NODE_COUNT)) u_back (
    .clk(clk), .rst(rst),
    .q_valid(q_valid), .q_pop(q_pop), .q_req(q_req), .q_bin(q_bin),
    .rsp_valid(rsp.valid), .rsp_ready(rsp.ready), .rsp_res(rsp_res)
  );

  assign rsp.status     = rsp_res.status;
  assign rsp.found      = rsp_res.found;
  assign rsp.read_value = rsp_res.read_value;
  assign rsp.entries    = rsp_res.entries;

endmodule

// File: tb/chained_hash_map_engine_tb.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// chained_hash_map_engine_tb
// Drives add, remove, lookup and invalid-function items into the hash map engine and checks
// every result against a behavioral map kept in the bench, across several
// bin_power settings, with random sender gaps and receiver stalls.
// ----------------------------------------------------------------------------
module chained_hash_map_engine_tb;

  localparam int NODES      = 1024;
  localparam int BINS       = 256;
  localparam int NIL        = NODES;
  localparam int IDLE_LIMIT = 20000;
  localparam logic [1:0] FUNC_BAD = 2'd3;
  localparam logic [0:0] REG_BIN_POWER = 1'b0;

  logic clk = 1'b0;
  logic rst = 1'b1;
  logic psel = 1'b0, penable = 1'b0, pwrite = 1'b0;
  logic [0:0] paddr = '0;
  logic [31:0] pwdata = '0;
  logic [31:0] prdata;
  logic pready;

  chm_req_if req ();
  chm_rsp_if rsp ();

  chained_hash_map_engine DUT (
    .clk(clk), .rst(rst), .req(req.sink), .rsp(rsp.source),
    .psel(psel), .penable(penable), .pwrite(pwrite), .paddr(paddr),
    .pwdata(pwdata), .prdata(prdata), .pready(pready)
  );

  initial begin
    forever #5 clk = ~clk;
  end

  // bench copy of the map
  logic [3:0]  map_power;
  int          map_heads [BINS];
  logic [63:0] map_keys  [NODES];
  logic [63:0] map_vals  [NODES];
  int          map_links [NODES];
  int          map_free  [NODES];
  int          map_depth;
  int          map_total;

  chm_pkg::rsp_t pending_rsp[$];
  logic [63:0] key_pool[$];
  int     fail_count = 0;
  int     idle_cycles = 0;
  int     stall_mode = 0;

  task automatic map_reset();
    map_power = chm_pkg::BIN_POWER_RESET;
    foreach (map_heads[i]) map_heads[i] = NIL;
    for (int i = 0; i < NODES; i++) begin
      map_links[i] = NIL;
      map_free[i] = i;
    end
    map_depth = NODES;
    map_total = 0;
  endtask

  function automatic int bin_index(logic [63:0] k);
    logic [63:0] h;
    int p;
    h = k * 64'd65521;
    p = (map_power < 1) ? 1 : (map_power > 8) ? 8 : map_power;
    return int'(h & ((64'd1 << p) - 1));
  endfunction

  function automatic chm_pkg::rsp_t map_apply(chm_pkg::req_t r);
    chm_pkg::rsp_t o;
    int b, cur, prev, hit, steps, n;
    b = bin_index(r.key);
    cur = map_heads[b];
    prev = NIL;
    hit = NIL;
    steps = 0;
    while (cur < NIL && steps < NODES) begin
      if (map_keys[cur] == r.key) begin
        hit = cur;
        break;
      end
      prev = cur;
      cur = map_links[cur];
      steps++;
    end
    if (hit == NIL) prev = NIL;
    o.status = chm_pkg::ST_NOT_FOUND;
    o.found = (hit < NIL);
    o.read_value = '0;
    case (r.func)
      chm_pkg::FUNC_ADD: begin
        if (hit < NIL) begin
          map_vals[hit] = r.new_value;
          o.status = chm_pkg::ST_UPDATED;
        end else if (map_depth == 0) begin
          o.status = chm_pkg::ST_POOL_FULL;
        end else begin
          map_depth--;
          n = map_free[map_depth];
          map_keys[n] = r.key;
          map_vals[n] = r.new_value;
          map_links[n] = map_heads[b];
          map_heads[b] = n;
          map_total++;
          o.status = chm_pkg::ST_INSERTED;
        end
      end
      chm_pkg::FUNC_REMOVE: begin
        if (hit < NIL) begin
          if (prev < NIL) map_links[prev] = map_links[hit];
          else map_heads[b] = map_links[hit];
          map_links[hit] = NIL;
          if (map_depth < NODES) begin
            map_free[map_depth] = hit;
            map_depth++;
          end
          if (map_total > 0) map_total--;
          o.status = chm_pkg::ST_REMOVED;
        end
      end
      chm_pkg::FUNC_LOOKUP: begin
        if (hit < NIL) begin
          o.read_value = map_vals[hit];
          o.status = chm_pkg::ST_UPDATED;
        end else begin
          o.read_value = r.miss_value;
        end
      end
      default: o.found = 1'b0;
    endcase
    o.entries = map_total[chm_pkg::ENTRY_W-1:0];
    return o;
  endfunction

  // predict at the accepting edge so order of items is kept
  always @(posedge clk) begin
    chm_pkg::req_t r;
    if (!rst && req.valid && req.ready) begin
      r.func = req.func;
      r.key = req.key;
      r.new_value = req.new_value;
      r.miss_value = req.miss_value;
      pending_rsp.push_back(map_apply(r));
    end
  end

  always @(posedge clk) begin
    chm_pkg::rsp_t e;
    if (!rst && rsp.valid && rsp.ready) begin
      if (pending_rsp.size() == 0) begin
        $error("result with no item outstanding");
        fail_count++;
      end else begin
        e = pending_rsp.pop_front();
        if (rsp.status !== e.status) begin
          $error("status exp %0d got %0d", e.status, rsp.status);
          fail_count++;
        end
        if (rsp.found !== e.found) begin
          $error("found exp %0d got %0d", e.found, rsp.found);
          fail_count++;
        end
        if (rsp.read_value !== e.read_value) begin
          $error("read_value exp %h got %h", e.read_value, rsp.read_value);
          fail_count++;
        end
        if (rsp.entries !== e.entries) begin
          $error("entries exp %0d got %0d", e.entries, rsp.entries);
          fail_count++;
        end
      end
    end
  end

  // receiver stall pattern
  always @(negedge clk) begin
    if (($urandom_range(0, 63)) == 0) stall_mode = $urandom_range(0, 3);
    case (stall_mode)
      0: rsp.ready <= 1'b1;
      1: rsp.ready <= ($urandom_range(0, 3) != 0);
      2: rsp.ready <= ($urandom_range(0, 1) != 0);
      default: rsp.ready <= ($urandom_range(0, 7) == 0);
    endcase
  end

  always @(posedge clk) begin
    if (rst || (req.valid && req.ready) || (rsp.valid && rsp.ready)) idle_cycles <= 0;
    else idle_cycles <= idle_cycles + 1;
    if (idle_cycles > IDLE_LIMIT) begin
      $display("chained_hash_map_engine verification failed");
      $finish;
    end
  end

  int burst_left = 0;

  // valid drops at the start of a gap, or in drain, so it is written once per step
  task automatic send_item(logic [1:0] f, logic [63:0] k, logic [63:0] nv,
                           logic [63:0] mv);
    if (burst_left == 0) begin
      req.valid <= 1'b0;
      repeat ($urandom_range(1, 6)) @(negedge clk);
      burst_left = $urandom_range(1, 20);
    end
    burst_left--;
    req.valid <= 1'b1;
    req.func <= f;
    req.key <= k;
    req.new_value <= nv;
    req.miss_value <= mv;
    @(posedge clk);
    while (!req.ready) @(posedge clk);
    @(negedge clk);
  endtask

  task automatic drain();
    req.valid <= 1'b0;
    burst_left = 0;
    while (pending_rsp.size() != 0) @(negedge clk);
    repeat (20) @(negedge clk);
  endtask

  task automatic write_bin_power(logic [3:0] v);
    drain();
    psel <= 1'b1; pwrite <= 1'b1; paddr <= REG_BIN_POWER; pwdata <= {28'd0, v};
    @(negedge clk);
    penable <= 1'b1;
    @(negedge clk);
    psel <= 1'b0; penable <= 1'b0; pwrite <= 1'b0;
    @(posedge clk);
    map_power = v;
    @(negedge clk);
  endtask

  function automatic logic [63:0] rand64();
    return {$urandom(), $urandom()};
  endfunction

  function automatic logic [63:0] pick_key();
    if (key_pool.size() != 0 && $urandom_range(0, 3) != 0)
      return key_pool[$urandom_range(0, key_pool.size() - 1)];
    return rand64();
  endfunction

  task automatic test_directed();
    send_item(chm_pkg::FUNC_LOOKUP, 64'd0, 64'd0, '1);
    send_item(chm_pkg::FUNC_ADD, 64'd0, '1, 64'd0);
    send_item(chm_pkg::FUNC_ADD, '1, 64'd0, '1);
    send_item(chm_pkg::FUNC_LOOKUP, '1, rand64(), 64'h5a5a);
    send_item(chm_pkg::FUNC_ADD, 64'd0, 64'h1234, 64'd0);
    send_item(chm_pkg::FUNC_LOOKUP, 64'd0, 64'd0, 64'd7);
    send_item(FUNC_BAD, 64'd0, '1, '1);
    send_item(chm_pkg::FUNC_REMOVE, 64'd0, '1, '1);
    send_item(chm_pkg::FUNC_REMOVE, 64'd0, 64'd0, 64'd0);
    send_item(chm_pkg::FUNC_LOOKUP, 64'd0, 64'd0, 64'hdead);
    // same-bin keys to build chains: multiples of 256 share bin 0
    for (int i = 1; i <= 4; i++) send_item(chm_pkg::FUNC_ADD, 64'(i) << 8, 64'(i), 64'd0);
    send_item(chm_pkg::FUNC_REMOVE, 64'd3 << 8, 64'd0, 64'd0);
    send_item(chm_pkg::FUNC_LOOKUP, 64'd2 << 8, 64'd0, 64'd0);
    send_item(chm_pkg::FUNC_REMOVE, 64'd4 << 8, 64'd0, 64'd0);
    send_item(chm_pkg::FUNC_REMOVE, 64'd1 << 8, 64'd0, 64'd0);
  endtask

  task automatic test_power_change();
    write_bin_power(4'd0);
    for (int i = 0; i < 8; i++) send_item(chm_pkg::FUNC_ADD, rand64(), rand64(), rand64());
    send_item(chm_pkg::FUNC_LOOKUP, 64'd2 << 8, 64'd0, 64'd9);
    write_bin_power(4'd15);
    send_item(chm_pkg::FUNC_LOOKUP, 64'd2 << 8, 64'd0, 64'd9);
    write_bin_power(4'd8);
  endtask

  task automatic test_random(int n, logic [3:0] pw);
    logic [63:0] k;
    int f;
    write_bin_power(pw);
    for (int i = 0; i < n; i++) begin
      k = pick_key();
      f = $urandom_range(0, 19);
      if (f < 8) begin
        send_item(chm_pkg::FUNC_ADD, k, rand64(), rand64());
        if (key_pool.size() < 200) key_pool.push_back(k);
      end else if (f < 12) send_item(chm_pkg::FUNC_REMOVE, k, rand64(), rand64());
      else if (f < 19) send_item(chm_pkg::FUNC_LOOKUP, k, rand64(), rand64());
      else send_item(FUNC_BAD, k, rand64(), rand64());
    end
  endtask

  task automatic test_pool_full();
    // distinct random keys fill the pool; 256 bins keep the chains short
    write_bin_power(4'd8);
    while (map_depth > 0) send_item(chm_pkg::FUNC_ADD, rand64(), rand64(), 64'd0);
    send_item(chm_pkg::FUNC_ADD, rand64(), rand64(), 64'd0);
    send_item(chm_pkg::FUNC_ADD, key_pool[0], 64'h77, 64'd0);
    send_item(chm_pkg::FUNC_LOOKUP, key_pool[0], 64'd0, 64'd0);
    send_item(chm_pkg::FUNC_REMOVE, key_pool[0], 64'd0, 64'd0);
    send_item(chm_pkg::FUNC_ADD, rand64(), rand64(), 64'd0);
  endtask

  initial begin
    req.valid = 1'b0;
    req.func = chm_pkg::FUNC_ADD;
    req.key = '0;
    req.new_value = '0;
    req.miss_value = '0;
    rsp.ready = 1'b0;
    map_reset();
    repeat (5) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;
    repeat (300) @(negedge clk);
    test_directed();
    test_power_change();
    test_random(50, 4'd8);
    test_random(30, 4'd1);
    test_random(30, 4'd3);
    test_random(40, 4'd8);
    test_pool_full();
    drain();
    if (fail_count == 0) $display("chained_hash_map_engine verification clean");
    else $display("chained_hash_map_engine verification failed");
    $finish;
  end
endmodule

// File: filelist.f
hdl/chm_pkg.sv
hdl/chm_if.sv
hdl/chm_ram.sv
hdl/chm_front.sv
hdl/chm_back.sv
hdl/chained_hash_map_engine.sv
tb/chained_hash_map_engine_tb.sv
